// ----- hw/rtl/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the scaled L2 distance block
// Holds fixed widths, the sum queue entry and the result engine states.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

  localparam int SUM_W       = 64;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SCALE_W     = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int NORM_W      = 37;
  localparam int PROD_W      = ROOT_W + SCALE_W;
  localparam int ROUND_W     = PROD_W + 1 - SCALE_FRAC;
  localparam int STEP_CNT_W  = $clog2(ROOT_W);
  localparam int OUT_TDATA_W = ((NORM_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [NORM_W-1:0]  NORM_MAX    = '1;

  // One finished volume: its sum of squares and whether the sum clipped.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } sum_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sld_front.sv -----
// ----------------------------------------------------------------------------
// sld_front: sample intake and saturating accumulator
// Squares the difference of each sample pair and adds it to the running sum;
// a last request hands the finished sum to the queue and clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0]    sample_a,
  input  wire logic [SAMPLE_WIDTH-1:0]    sample_b,
  input  wire logic                       last,
  input  wire logic                       queue_full,
  output logic                            push,
  output sld_pkg::sum_entry_t             push_entry
);

  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int SQ_W   = 2 * SAMPLE_WIDTH;

  logic signed [DIFF_W-1:0]       diff;
  logic [DIFF_W-1:0]              diff_abs;
  logic [SAMPLE_WIDTH-1:0]        mag;
  logic [SQ_W-1:0]                sq_calc;

  logic                           s1_valid;
  logic                           s1_last;
  logic [SQ_W-1:0]                s1_sq;

  logic [sld_pkg::SUM_W-1:0]      sum;
  logic                           ovf;
  logic [sld_pkg::SUM_W:0]        total;
  logic [sld_pkg::SUM_W-1:0]      sum_next;
  logic                           ovf_next;
  logic                           advance;

  assign diff     = $signed({sample_a[SAMPLE_WIDTH-1], sample_a})
                  - $signed({sample_b[SAMPLE_WIDTH-1], sample_b});
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  // The magnitude never exceeds 2^SAMPLE_WIDTH - 1, so the top bit drops.
  assign mag      = diff_abs[SAMPLE_WIDTH-1:0];
  assign sq_calc  = mag * mag;

  // The whole front holds only when a last request finds the queue full.
  assign advance  = !(s1_valid && s1_last && queue_full);
  assign in_ready = advance;

  always_comb begin
    total    = {1'b0, sum} + (sld_pkg::SUM_W + 1)'(s1_sq);
    sum_next = total[sld_pkg::SUM_W] ? '1 : total[sld_pkg::SUM_W-1:0];
    ovf_next = ovf | total[sld_pkg::SUM_W];
  end

  assign push           = advance && s1_valid && s1_last;
  assign push_entry.sum = sum_next;
  assign push_entry.ovf = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_last <= last;
      s1_sq   <= sq_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      ovf <= 1'b0;
    end else if (advance && s1_valid) begin
      if (s1_last) begin
        sum <= '0;
        ovf <= 1'b0;
      end else begin
        sum <= sum_next;
        ovf <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sld_queue.sv -----
// ----------------------------------------------------------------------------
// sld_queue: short queue of finished volume sums
// Decouples the accumulator from the square root engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire sld_pkg::sum_entry_t   push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output sld_pkg::sum_entry_t        head,
  output logic [sld_pkg::QCNT_W-1:0] count
);

  sld_pkg::sum_entry_t               slots [sld_pkg::QUEUE_DEPTH];
  logic [sld_pkg::QPTR_W-1:0]        wr_ptr;
  logic [sld_pkg::QPTR_W-1:0]        rd_ptr;

  assign full      = (count == sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sld_back.sv -----
// ----------------------------------------------------------------------------
// sld_back: square root, scaling and result register
// Takes the integer square root two sum bits per cycle, multiplies it by the
// scale, rounds at the binary point, clips and holds the result for output.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire sld_pkg::sum_entry_t           q_head,
  output logic                               pop,
  input  wire logic [sld_pkg::SCALE_W-1:0]   scale_root,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sld_pkg::NORM_W-1:0]         norm,
  output logic                               saturated
);

  sld_pkg::back_state_t               state;
  sld_pkg::back_state_t               state_next;

  logic [sld_pkg::SUM_W-1:0]          rad;
  logic [sld_pkg::REM_W-1:0]          rem;
  logic [sld_pkg::ROOT_W-1:0]         root;
  logic [sld_pkg::STEP_CNT_W-1:0]     cnt;
  logic                               ovf;
  logic [sld_pkg::PROD_W-1:0]         prod;

  logic [sld_pkg::REM_W-1:0]          rem_sh;
  logic [sld_pkg::REM_W-1:0]          trial;
  logic                               fits;
  logic [sld_pkg::PROD_W:0]           rounded_full;
  logic [sld_pkg::ROUND_W-1:0]        rounded;
  logic [sld_pkg::NORM_W-1:0]         norm_calc;
  logic                               out_free;

  assign out_free = !out_valid || out_ready;

  // One restoring square root step: bring down two bits, try 4r + 1.
  always_comb begin
    rem_sh = {rem[sld_pkg::REM_W-3:0], rad[sld_pkg::SUM_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_comb begin
    rounded_full = {1'b0, prod} + (sld_pkg::PROD_W + 1)'(1 << (sld_pkg::SCALE_FRAC - 1));
    rounded      = rounded_full[sld_pkg::PROD_W:sld_pkg::SCALE_FRAC];
    norm_calc    = (rounded > sld_pkg::ROUND_W'(sld_pkg::NORM_MAX))
                 ? sld_pkg::NORM_MAX : rounded[sld_pkg::NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      sld_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = sld_pkg::ST_ROOT;
        end
      end
      sld_pkg::ST_ROOT: begin
        if (cnt == '0) begin
          state_next = sld_pkg::ST_MUL;
        end
      end
      sld_pkg::ST_MUL: begin
        state_next = sld_pkg::ST_DONE;
      end
      sld_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sld_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == sld_pkg::ST_IDLE && q_valid) begin
      rad  <= q_head.sum;
      ovf  <= q_head.ovf;
      rem  <= '0;
      root <= '0;
      cnt  <= sld_pkg::STEP_CNT_W'(sld_pkg::ROOT_W - 1);
    end else if (state == sld_pkg::ST_ROOT) begin
      rad  <= {rad[sld_pkg::SUM_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[sld_pkg::ROOT_W-2:0], fits};
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sld_pkg::ST_MUL) begin
      prod <= root * scale_root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sld_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sld_pkg::ST_DONE && out_free) begin
      norm      <= norm_calc;
      saturated <= ovf;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scaled_l2_distance.sv -----
// ----------------------------------------------------------------------------
// scaled_l2_distance: scaled Euclidean norm of the difference of two volumes
// Accumulates squared sample differences and reports the scaled square root.
// ----------------------------------------------------------------------------
// Usage: each request on the s_axis channel carries one pair of co-located
// samples; s_axis_tlast marks the final pair of a volume. The front end takes
// one request per cycle and keeps a saturating 64-bit sum of squares. On the
// last pair the sum goes into a two-entry queue, and the result engine sends
// one m_axis request: isqrt(sum) times scale_root, rounded at the Q8.16 point
// and clipped to 37 bits, with tuser flagging a clipped sum.
// From the last pair to m_axis_tvalid the sum passes the front stage register,
// the queue, the root load, 32 root steps (two sum bits per cycle), the
// multiply register and the rounded output register. The root engine takes a
// new volume only once the last result is registered, so short volumes fill
// the queue and s_axis_tready drops until it drains.
// A held result does not block a new root; the engine waits only when the
// next result is ready and m_axis_tready is still low.
// Reset empties the pipeline and queue, clears the sum and sets scale_root to
// 1.0. Write scale_root through cfg_we and cfg_wdata only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_l2_distance #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [sld_pkg::SCALE_W-1:0]       cfg_wdata,     // scale_root
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample_a, sample_b
  input  wire logic                              s_axis_tlast,  // last
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [sld_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // norm, zero pad
  output logic [0:0]                             m_axis_tuser   // saturated
);

  logic [sld_pkg::SCALE_W-1:0]  scale_root;
  logic                         q_push;
  sld_pkg::sum_entry_t          q_push_entry;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_not_empty;
  sld_pkg::sum_entry_t          q_head;
  logic [sld_pkg::QCNT_W-1:0]   q_count;
  logic [sld_pkg::NORM_W-1:0]   norm;
  logic                         saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_root <= sld_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_root <= cfg_wdata;
    end
  end

  sld_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .sample_a   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_b   (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .last       (s_axis_tlast),
    .queue_full (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  sld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head),
    .count      (q_count)
  );

  sld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .pop        (q_pop),
    .scale_root (scale_root),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .norm       (norm),
    .saturated  (saturated)
  );

  assign m_axis_tdata = sld_pkg::OUT_TDATA_W'(norm);
  assign m_axis_tuser = saturated;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("sum queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("sum queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH))
    else $error("sum queue count beyond depth");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && q_count == '0))
    else $error("result or queue not empty after reset");
`endif

endmodule

`default_nettype wire
